>>> rtl/iir_df2t_sixth_order_fixed_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sixth-order IIR filter
// Clocked on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef IIR_DF2T_SIXTH_ORDER_FIXED_TOP_ASSERT_SVH
`define IIR_DF2T_SIXTH_ORDER_FIXED_TOP_ASSERT_SVH

// same-cycle implication
`define IIR6_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("iir6 assertion failed");

// next-cycle implication
`define IIR6_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("iir6 assertion failed");

`endif

>>> rtl/iir6_pkg.sv
// ----------------------------------------------------------------------------
// iir6_pkg
// Types, widths and Q8.32 coefficient tables for the sixth-order IIR filter.
// ----------------------------------------------------------------------------
package iir6_pkg;

    localparam int SAMPLE_W = 16;
    localparam int Q_W      = 32;           // Q16.16 word
    localparam int ACC_W    = 64;           // Q.48 accumulator, wraps mod 2^64
    localparam int MUL_A_W  = 32;
    localparam int MUL_B_W  = 21;           // 20-bit coefficient slice plus sign
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int SLICE_W  = 20;
    localparam int COEF_W   = 40;
    localparam int COEF_N   = 16;
    localparam int KIDX_W   = 4;
    localparam int DEST_W   = 4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_Y,
        ST_TAP,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        PH_XB,      // x * b[k], seeded with the lower delay register
        PH_AL,      // - y * a[k], low slice
        PH_AH       // - y * a[k], high slice, then write back
    } phase_t;

    typedef struct packed {
        logic              valid;
        logic              init;    // seed accumulator from init value
        logic              sub;
        logic              hi;      // product weighted by 2^SLICE_W
        logic              wr;      // write sum into delay register dest
        logic              is_y;    // sum is the new output y
        logic [DEST_W-1:0] dest;
    } mac_ctl_t;

    // b0..b6, Q8.32, all below 2^20 so the low slice carries them whole
    localparam logic signed [COEF_W-1:0] COEF_B [COEF_N] = '{
        40'h000000084F, 40'h00000031DD, 40'h0000007CA8, 40'h000000A636,
        40'h0000007CA8, 40'h00000031DD, 40'h000000084F, 40'h0000000000,
        40'h0000000000, 40'h0000000000, 40'h0000000000, 40'h0000000000,
        40'h0000000000, 40'h0000000000, 40'h0000000000, 40'h0000000000
    };

    // a0..a6, Q8.32 two's complement (a0 implied, never used)
    localparam logic signed [COEF_W-1:0] COEF_A [COEF_N] = '{
        40'h0100000000, 40'hFABA638B78, 40'h0B9EB3953A, 40'hF24C1C1EA7,
        40'h091DB68557, 40'hFCC1AF3CAE, 40'h007B691280, 40'h0000000000,
        40'h0000000000, 40'h0000000000, 40'h0000000000, 40'h0000000000,
        40'h0000000000, 40'h0000000000, 40'h0000000000, 40'h0000000000
    };

endpackage

>>> rtl/iir6_mac.sv
// ----------------------------------------------------------------------------
// iir6_mac
// Shared multiply-accumulate: registered 32x21 product, then 64-bit add/sub.
// ----------------------------------------------------------------------------
module iir6_mac (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic signed [iir6_pkg::MUL_A_W-1:0]   op_a,
    input  logic signed [iir6_pkg::MUL_B_W-1:0]   op_b,
    input  iir6_pkg::mac_ctl_t                    op_ctl,
    input  logic        [iir6_pkg::ACC_W-1:0]     init_val,
    output iir6_pkg::mac_ctl_t                    acc_ctl,
    output logic        [iir6_pkg::ACC_W-1:0]     acc_sum
);
    import iir6_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    mac_ctl_t                 ctl_reg;
    logic        [ACC_W-1:0]  acc_reg;
    logic        [ACC_W-1:0]  prod_ext;
    logic        [ACC_W-1:0]  addend;
    logic        [ACC_W-1:0]  base;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else begin
            ctl_reg <= op_ctl;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
        if (ctl_reg.valid) begin
            acc_reg <= acc_sum;
        end
    end

    always_comb begin
        prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        addend   = ctl_reg.hi ? (prod_ext << SLICE_W) : prod_ext;
        base     = ctl_reg.init ? init_val : acc_reg;
        acc_sum  = ctl_reg.sub ? (base - addend) : (base + addend);
    end

    assign acc_ctl = ctl_reg;

endmodule

>>> rtl/iir_df2t_sixth_order_fixed_top.sv
// ----------------------------------------------------------------------------
// iir_df2t_sixth_order_fixed_top
// Sixth-order transposed direct form II IIR filter, Q16.16 with Q8.32 taps.
// ----------------------------------------------------------------------------
// Each accepted sample steps through ST_Y, the ST_TAP phases XB, AL and AH for each delay
// register, and ST_OUT: 3*TAPS-2 products on the single shared multiplier. A new sample
// is taken only after ST_OUT loads the result, which back-pressure on m_tready can hold.
// s_tready is high only while idle; a finished result waits in the output register.
// Reset (aresetn low, synchronous) clears the delay registers, sequencer and m_tvalid.
// ----------------------------------------------------------------------------
`include "iir_df2t_sixth_order_fixed_top_assert.svh"

module iir_df2t_sixth_order_fixed_top #(
    parameter int TAPS = 7                  // 2..16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,            // [15:0] sample, [19:16] in_keep,
                                            // [23:20] in_strb, [24] in_dest,
                                            // [25] in_id, [31:26] zero
    input  logic        s_tlast,            // in_last
    input  logic        s_tuser,            // in_user
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,            // [15:0] filtered, [19:16] out_keep,
                                            // [23:20] out_strb, [24] out_dest,
                                            // [25] out_id, [31:26] zero
    output logic        m_tlast,            // out_last
    output logic        m_tuser             // out_user
);
    import iir6_pkg::*;

    localparam int NDLY = TAPS - 1;
    localparam int DW   = (NDLY > 1) ? $clog2(NDLY) : 1;
    localparam logic [DW-1:0] TOP_IDX = DW'(TAPS - 2);

    // ---------------------------------------------------------------------
    // State
    // ---------------------------------------------------------------------
    state_t                 state_reg, state_next;
    phase_t                 phase_reg, phase_next;
    logic [DW-1:0]          tap_reg, tap_next;     // delay register being built

    logic signed [SAMPLE_W-1:0] x_reg;
    logic [3:0]             keep_reg, strb_reg;
    logic                   last_reg, dest_reg, id_reg, user_reg;
    logic [Q_W-1:0]         y_reg;
    logic [Q_W-1:0]         delay_reg [NDLY];

    logic                   m_valid_reg;
    logic [SAMPLE_W-1:0]    m_filt_reg;
    logic [3:0]             m_keep_reg, m_strb_reg;
    logic                   m_last_reg, m_dest_reg, m_id_reg, m_user_reg;

    // shared unit
    logic signed [MUL_A_W-1:0] op_a;
    logic signed [MUL_B_W-1:0] op_b;
    mac_ctl_t               op_ctl;
    mac_ctl_t               acc_ctl;
    logic [ACC_W-1:0]       init_val;
    logic [ACC_W-1:0]       acc_sum;

    logic [KIDX_W-1:0]      kidx;
    logic signed [MUL_A_W-1:0] x_q;
    logic                   out_load;
    logic [SAMPLE_W-1:0]    filt_int;
    logic [DW-1:0]          lower_idx;

    // ---------------------------------------------------------------------
    // Handshake
    // ---------------------------------------------------------------------
    assign s_tready = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_tready);

    // ---------------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        tap_next   = tap_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_Y;
                end
            end
            ST_Y: begin
                state_next = ST_TAP;
                phase_next = PH_XB;
                tap_next   = TOP_IDX;
            end
            ST_TAP: begin
                unique case (phase_reg)
                    PH_XB: phase_next = PH_AL;
                    PH_AL: phase_next = PH_AH;
                    PH_AH: begin
                        phase_next = PH_XB;
                        if (tap_reg == '0) begin
                            state_next = ST_OUT;
                        end else begin
                            tap_next = tap_reg - 1'b1;
                        end
                    end
                    default: phase_next = PH_XB;
                endcase
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------------
    // Sequencer: operations issued to the shared unit
    // ---------------------------------------------------------------------
    assign x_q  = {x_reg, 16'h0000};                   // sample as Q16.16
    assign kidx = KIDX_W'(TAPS - 1) - KIDX_W'(tap_reg);

    always_comb begin
        op_a   = '0;
        op_b   = '0;
        op_ctl = '0;
        unique case (state_reg)
            ST_Y: begin
                // y = x*b0 + top delay register (value before this sample)
                op_a        = x_q;
                op_b        = {1'b0, COEF_B[0][SLICE_W-1:0]};
                op_ctl.valid = 1'b1;
                op_ctl.init  = 1'b1;
                op_ctl.is_y  = 1'b1;
            end
            ST_TAP: begin
                op_ctl.valid = 1'b1;
                op_ctl.dest  = DEST_W'(tap_reg);
                unique case (phase_reg)
                    PH_XB: begin
                        // b taps fit the low slice whole
                        op_a        = x_q;
                        op_b        = {1'b0, COEF_B[kidx][SLICE_W-1:0]};
                        op_ctl.init = 1'b1;
                    end
                    PH_AL: begin
                        op_a       = y_reg;
                        op_b       = {1'b0, COEF_A[kidx][SLICE_W-1:0]};
                        op_ctl.sub = 1'b1;
                    end
                    PH_AH: begin
                        op_a       = y_reg;
                        op_b       = {COEF_A[kidx][COEF_W-1], COEF_A[kidx][COEF_W-1:SLICE_W]};
                        op_ctl.sub = 1'b1;
                        op_ctl.hi  = 1'b1;
                        op_ctl.wr  = 1'b1;
                    end
                    default: op_ctl.valid = 1'b0;
                endcase
            end
            ST_IDLE, ST_OUT: begin
                op_ctl = '0;
            end
            default: op_ctl = '0;
        endcase
    end

    // accumulator seed, read as the operation reaches the add stage
    assign lower_idx = acc_ctl.dest[DW-1:0] - 1'b1;

    always_comb begin
        if (acc_ctl.is_y) begin
            init_val = {delay_reg[TOP_IDX], 32'h0};
        end else if (acc_ctl.dest == '0) begin
            init_val = '0;                               // bottom register has no lower one
        end else begin
            init_val = {delay_reg[lower_idx], 32'h0};
        end
    end

    iir6_mac u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op_a     (op_a),
        .op_b     (op_b),
        .op_ctl   (op_ctl),
        .init_val (init_val),
        .acc_ctl  (acc_ctl),
        .acc_sum  (acc_sum)
    );

    // ---------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_XB;
            tap_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NDLY; i++) begin
                delay_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            tap_reg   <= tap_next;
            // sums truncate to Q16.16 by dropping the low 32 bits
            if (acc_ctl.valid && acc_ctl.wr) begin
                delay_reg[acc_ctl.dest[DW-1:0]] <= acc_sum[ACC_W-1:ACC_W-Q_W];
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            x_reg    <= s_tdata[15:0];
            keep_reg <= s_tdata[19:16];
            strb_reg <= s_tdata[23:20];
            dest_reg <= s_tdata[24];
            id_reg   <= s_tdata[25];
            last_reg <= s_tlast;
            user_reg <= s_tuser;
        end
        if (acc_ctl.valid && acc_ctl.is_y) begin
            y_reg <= acc_sum[ACC_W-1:ACC_W-Q_W];
        end
        if (out_load) begin
            m_filt_reg <= filt_int;
            m_keep_reg <= keep_reg;
            m_strb_reg <= strb_reg;
            m_last_reg <= last_reg;
            m_dest_reg <= dest_reg;
            m_id_reg   <= id_reg;
            m_user_reg <= user_reg;
        end
    end

    // Q16.16 to integer, truncating toward zero: negative with a fraction rounds up
    assign filt_int = y_reg[31:16] + SAMPLE_W'(y_reg[31] && (y_reg[15:0] != '0));

    // ---------------------------------------------------------------------
    // Outputs
    // ---------------------------------------------------------------------
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, m_id_reg, m_dest_reg, m_strb_reg, m_keep_reg, m_filt_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    `IIR6_ASSERT_NXT(a_accept_starts_y, s_tvalid && s_tready, state_reg == ST_Y)
    `IIR6_ASSERT_IMP(a_no_write_idle, acc_ctl.valid && acc_ctl.wr, state_reg != ST_IDLE)
    `IIR6_ASSERT_IMP(a_y_after_issue, acc_ctl.valid && acc_ctl.is_y, $past(state_reg) == ST_Y)
    `IIR6_ASSERT_IMP(a_result_from_out, $rose(m_tvalid), $past(state_reg) == ST_OUT)

endmodule

>>> tb/iir_df2t_sixth_order_fixed_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the sixth-order transposed direct form II IIR filter
// Drives sample requests through the input stream and checks every filtered
// request on the result stream against a bit-exact Q16.16 / Q8.32 predictor.
// A short directed table comes first, then shaped random runs under
// varying source idling and sink back-pressure.
// ----------------------------------------------------------------------------
module iir_df2t_sixth_order_fixed_top_tb;

    localparam int TAPS          = 7;
    localparam int ITEMS_PER_PH  = 325;     // five phases plus the table, about 1650
    localparam int NUM_PHASES    = 5;
    localparam int DRAIN_CYCLES  = 40;
    localparam int STALL_LIMIT   = 2000;    // cycles with no handshake at all

    // Idling per phase: quiet, source idle, sink stall, both, quiet again
    localparam int SEND_IDLE_PCT [NUM_PHASES] = '{0, 86, 0, 36, 0};
    localparam int SINK_STALL_PCT[NUM_PHASES] = '{0, 0, 86, 36, 0};

    // Q8.32 taps held in 64 bits so products wrap the same way as the Q.48 sums
    localparam logic [63:0] TAP_B [TAPS] = '{
        64'h000000000000084F, 64'h00000000000031DD, 64'h0000000000007CA8,
        64'h000000000000A636, 64'h0000000000007CA8, 64'h00000000000031DD,
        64'h000000000000084F
    };
    localparam logic [63:0] TAP_A [TAPS] = '{
        64'h0000000100000000, 64'hFFFFFFFABA638B78, 64'h0000000B9EB3953A,
        64'hFFFFFFF24C1C1EA7, 64'h000000091DB68557, 64'hFFFFFFFCC1AF3CAE,
        64'h000000007B691280
    };

    typedef struct packed {
        logic [15:0] sample;
        logic [3:0]  keep;
        logic [3:0]  strb;
        logic        last;
        logic        dest;
        logic        id;
        logic        user;
    } sample_req_t;

    typedef struct packed {
        logic [15:0] filtered;
        logic [3:0]  keep;
        logic [3:0]  strb;
        logic        last;
        logic        dest;
        logic        id;
        logic        user;
    } filt_res_t;

    typedef struct packed {
        sample_req_t req;
        logic        has_exp;   // typed-in output overrides the predictor
        logic [15:0] exp_out;
    } dir_row_t;

    typedef enum logic [1:0] {
        SEQ_NOISE,      // full-scale white noise
        SEQ_QUIET,      // low-amplitude noise around zero
        SEQ_STEP,       // one value held for the whole run
        SEQ_NYQUIST     // alternating full-scale extremes
    } seq_kind_t;

    localparam int DIR_ROWS = 25;

    // Directed table. Only the first two rows are obvious by inspection:
    // with cleared delay registers the output is x*b0, a tiny fraction of x,
    // which truncates toward zero to 0 for zero and for the negative extreme.
    dir_row_t dir_table [DIR_ROWS] = '{
        '{'{16'h0000, 4'h0, 4'h0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, 16'h0000},
        '{'{16'h8000, 4'hF, 4'hF, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b1, 16'h0000},
        '{'{16'h7FFF, 4'h0, 4'hF, 1'b0, 1'b0, 1'b1, 1'b0}, 1'b0, 16'h0000},
        '{'{16'h7FFF, 4'hF, 4'h0, 1'b0, 1'b1, 1'b0, 1'b1}, 1'b0, 16'h0000},
        '{'{16'h7FFF, 4'h5, 4'hA, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, 16'h0000},
        '{'{16'h7FFF, 4'hA, 4'h5, 1'b0, 1'b1, 1'b1, 1'b1}, 1'b0, 16'h0000},
        // last marker mid-stream: state must carry straight on
        '{'{16'h7FFF, 4'h3, 4'hC, 1'b1, 1'b0, 1'b0, 1'b1}, 1'b0, 16'h0000},
        '{'{16'h7FFF, 4'hC, 4'h3, 1'b0, 1'b0, 1'b1, 1'b0}, 1'b0, 16'h0000},
        '{'{16'h7FFF, 4'h1, 4'h8, 1'b0, 1'b1, 1'b0, 1'b0}, 1'b0, 16'h0000},
        '{'{16'h7FFF, 4'h8, 4'h1, 1'b0, 1'b0, 1'b0, 1'b1}, 1'b0, 16'h0000},
        '{'{16'h7FFF, 4'hF, 4'hF, 1'b0, 1'b1, 1'b1, 1'b1}, 1'b0, 16'h0000},
        '{'{16'h7FFF, 4'h0, 4'h0, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, 16'h0000},
        '{'{16'h7FFF, 4'h6, 4'h9, 1'b0, 1'b0, 1'b1, 1'b0}, 1'b0, 16'h0000},
        // full-scale alternation, worst case for the feedback path
        '{'{16'h8000, 4'h9, 4'h6, 1'b0, 1'b1, 1'b0, 1'b1}, 1'b0, 16'h0000},
        '{'{16'h7FFF, 4'h2, 4'h4, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, 16'h0000},
        '{'{16'h8000, 4'h4, 4'h2, 1'b0, 1'b1, 1'b1, 1'b1}, 1'b0, 16'h0000},
        '{'{16'h7FFF, 4'h7, 4'hE, 1'b0, 1'b0, 1'b0, 1'b1}, 1'b0, 16'h0000},
        '{'{16'h8000, 4'hE, 4'h7, 1'b1, 1'b1, 1'b1, 1'b0}, 1'b0, 16'h0000},
        '{'{16'h7FFF, 4'hB, 4'hD, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, 16'h0000},
        // zero input: ringing from the stored state only, then -1 and +1
        '{'{16'h0000, 4'hD, 4'hB, 1'b0, 1'b1, 1'b0, 1'b1}, 1'b0, 16'h0000},
        '{'{16'h0000, 4'h0, 4'h0, 1'b0, 1'b0, 1'b1, 1'b0}, 1'b0, 16'h0000},
        '{'{16'h0000, 4'hF, 4'hF, 1'b0, 1'b1, 1'b0, 1'b1}, 1'b0, 16'h0000},
        '{'{16'h0000, 4'h1, 4'h2, 1'b1, 1'b0, 1'b1, 1'b0}, 1'b0, 16'h0000},
        '{'{16'hFFFF, 4'h4, 4'h8, 1'b0, 1'b1, 1'b1, 1'b1}, 1'b0, 16'h0000},
        '{'{16'h0001, 4'h8, 4'h4, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, 16'h0000}
    };

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;       // [15:0] sample, [19:16] keep, [23:20] strb,
                                // [24] dest, [25] id, [31:26] zero
    logic        s_tlast;       // last
    logic        s_tuser;       // user
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;       // [15:0] filtered, [19:16] keep, [23:20] strb,
                                // [24] dest, [25] id, [31:26] zero
    logic        m_tlast;       // last
    logic        m_tuser;       // user

    // Predictor state: six Q16.16 delay registers, cleared at reset
    logic [31:0] delay_q [TAPS-1];
    filt_res_t   pending_outputs [$];
    int          mismatch_count;
    int          send_idle_pct;
    int          sink_stall_pct;

    iir_df2t_sixth_order_fixed_top #(
        .TAPS (TAPS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // One filter update. All arithmetic is mod 2^64 at 48 fraction bits;
    // each sum keeps bits [63:32], i.e. floor to Q16.16 and wrap to 32 bits.
    function automatic logic [15:0] filter_sample(input logic [15:0] smp);
        logic [63:0] x_q;
        logic [63:0] y_ext;
        logic [63:0] sum;
        logic [31:0] y_q;
        logic [31:0] whole;
        x_q   = {{32{smp[15]}}, smp, 16'h0000};
        // top register as it stood before this request
        sum   = x_q * TAP_B[0] + {delay_q[TAPS-2], 32'h0};
        y_q   = sum[63:32];
        y_ext = {{32{y_q[31]}}, y_q};
        // descending, so each update sees the old lower register
        for (int i = TAPS - 2; i > 0; i--) begin
            sum        = {delay_q[i-1], 32'h0} + x_q * TAP_B[TAPS-1-i]
                         - y_ext * TAP_A[TAPS-1-i];
            delay_q[i] = sum[63:32];
        end
        sum        = x_q * TAP_B[TAPS-1] - y_ext * TAP_A[TAPS-1];
        delay_q[0] = sum[63:32];
        // truncate toward zero: negatives with a fraction move up by one
        whole = {{16{y_q[31]}}, y_q[31:16]};
        if (y_q[31] && (y_q[15:0] != 16'h0))
            whole = whole + 32'd1;
        return whole[15:0];
    endfunction

    // Present one request, honour source idling, wait for the handshake and
    // queue the expected result at the accepting edge.
    task automatic send_sample(input sample_req_t req, input logic has_exp,
                               input logic [15:0] exp_out);
        filt_res_t want;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, req.id, req.dest, req.strb, req.keep, req.sample};
        s_tlast  <= req.last;
        s_tuser  <= req.user;
        do @(posedge aclk); while (!s_tready);
        want.filtered = filter_sample(req.sample);
        if (has_exp)
            want.filtered = exp_out;
        want.keep = req.keep;
        want.strb = req.strb;
        want.last = req.last;
        want.dest = req.dest;
        want.id   = req.id;
        want.user = req.user;
        pending_outputs.push_back(want);
    endtask

    // Sink back-pressure, redrawn every cycle
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Result checker: every accepted result against the oldest expectation
    always @(posedge aclk) begin
        filt_res_t got;
        filt_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[15:0], m_tdata[19:16], m_tdata[23:20], m_tlast,
                   m_tdata[24], m_tdata[25], m_tuser};
            if (pending_outputs.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected result filtered=%0d keep=%h strb=%h",
                             $realtime, $signed(got.filtered), got.keep, got.strb);
            end else begin
                want = pending_outputs.pop_front();
                if (got.filtered !== want.filtered || got.keep !== want.keep ||
                    got.strb !== want.strb || got.last !== want.last ||
                    got.dest !== want.dest || got.id !== want.id ||
                    got.user !== want.user) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: exp filt=%0d k=%h s=%h l%b d%b i%b u%b",
                                 $realtime, $signed(want.filtered), want.keep,
                                 want.strb, want.last, want.dest, want.id, want.user);
                        $display("%0t: got filt=%0d k=%h s=%h l%b d%b i%b u%b",
                                 $realtime, $signed(got.filtered), got.keep,
                                 got.strb, got.last, got.dest, got.id, got.user);
                    end
                end
            end
        end
    end

    // Watchdog: too long without any request moving on either side
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        sample_req_t req;
        seq_kind_t   kind;
        logic [15:0] held;
        int          run_len;
        int          sent;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        s_tuser        = 1'b0;
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        for (int i = 0; i < TAPS - 1; i++)
            delay_q[i] = 32'h0;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed table, no idling
        for (int r = 0; r < DIR_ROWS; r++)
            send_sample(dir_table[r].req, dir_table[r].has_exp, dir_table[r].exp_out);

        // random runs: mostly shaped sequences so the state builds up and
        // reaches wrap-around, with some plain noise mixed in
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            send_idle_pct  = SEND_IDLE_PCT[ph];
            sink_stall_pct = SINK_STALL_PCT[ph];
            sent = 0;
            while (sent < ITEMS_PER_PH) begin
                kind    = seq_kind_t'($urandom_range(3));
                run_len = $urandom_range(40, 1);
                if (kind == SEQ_STEP && $urandom_range(3) == 0)
                    run_len = $urandom_range(250, 60);  // long hold: DC overshoot
                if (run_len > ITEMS_PER_PH - sent)
                    run_len = ITEMS_PER_PH - sent;
                held = 16'($urandom_range(65535));
                if ($urandom_range(3) == 0)
                    held = $urandom_range(1) ? 16'h7FFF : 16'h8000;
                for (int k = 0; k < run_len; k++) begin
                    case (kind)
                        SEQ_NOISE:   req.sample = 16'($urandom_range(65535));
                        SEQ_QUIET:   req.sample = 16'($urandom_range(511)) - 16'd256;
                        SEQ_STEP:    req.sample = held;
                        default:     req.sample = k[0] ? 16'h7FFF : 16'h8000;
                    endcase
                    req.keep = 4'($urandom_range(15));
                    req.strb = 4'($urandom_range(15));
                    req.last = (k == run_len - 1) || ($urandom_range(7) == 0);
                    req.dest = 1'($urandom_range(1));
                    req.id   = 1'($urandom_range(1));
                    req.user = 1'($urandom_range(1));
                    send_sample(req, 1'b0, 16'h0000);
                    sent++;
                end
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;

        while (pending_outputs.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && pending_outputs.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
